// ----- rtl/lcps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared constants, mode codes and types for the LED chaser pattern sequencer.
// ----------------------------------------------------------------------------
package lcps_pkg;

   localparam int NUM_LEDS   = 32;
   localparam int HALF_LO_W  = NUM_LEDS / 2;
   localparam int HALF_UP_W  = NUM_LEDS - HALF_LO_W;
   localparam int STEP_W     = $clog2(2 * NUM_LEDS + 2);
   localparam int DOT_W      = $clog2(NUM_LEDS + 1);
   localparam int LEDS_OUT_W = 32;
   localparam int WORD_EXT_W = (NUM_LEDS > LEDS_OUT_W) ? NUM_LEDS : LEDS_OUT_W;

   localparam logic [STEP_W-1:0] STEP_LEDS = STEP_W'(NUM_LEDS);
   localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(2 * NUM_LEDS);
   localparam logic [STEP_W-1:0] STEP_HALF = STEP_W'(NUM_LEDS / 2);

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_KEY  = 1'b1;

   localparam logic [3:0] MODE_NONE       = 4'd0;
   localparam logic [3:0] MODE_BLINK      = 4'd1;
   localparam logic [3:0] MODE_FILL_LEFT  = 4'd2;
   localparam logic [3:0] MODE_FILL_RIGHT = 4'd3;
   localparam logic [3:0] MODE_OUTSIDE_IN = 4'd4;
   localparam logic [3:0] MODE_INSIDE_OUT = 4'd5;
   localparam logic [3:0] MODE_STACK_LOW  = 4'd6;
   localparam logic [3:0] MODE_STACK_HIGH = 4'd7;

   typedef struct packed {
      logic [3:0]          mode;
      logic [NUM_LEDS-1:0] word;
      logic [STEP_W-1:0]   step;
      logic [DOT_W-1:0]    dot;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [3:0] key;
   } item_type;

endpackage

// ----- rtl/lcps_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_in_stage
// Input register for requests; stalls the sender while its entry cannot move.
// ----------------------------------------------------------------------------
module lcps_in_stage
   import lcps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   input  logic [3:0] req_key,
   output logic       req_stall,
   input  logic       out_ready,
   output item_type   item
);

   item_type item_ff;
   item_type item_in;

   assign req_stall = item_ff.valid & ~out_ready;

   always_comb begin
      item_in = item_ff;
      if (!req_stall) begin
         item_in.valid = req_valid;
         if (req_valid) begin
            item_in.kind = req_kind;
            item_in.key  = req_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.kind <= item_in.kind;
      item_ff.key  <= item_in.key;
   end

   assign item = item_ff;

endmodule

// ----- rtl/lcps_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcps_step
// Next-state logic: one animation step or one key press.
// ----------------------------------------------------------------------------
module lcps_step
   import lcps_pkg::*;
(
   input  logic      kind,
   input  logic [3:0] key,
   input  state_type cur,
   output state_type nxt,
   output logic      refreshed
);

   localparam logic [NUM_LEDS-1:0] ALL_ONES = {NUM_LEDS{1'b1}};
   localparam logic [NUM_LEDS-1:0] BIT_LO   = NUM_LEDS'(1);
   localparam logic [NUM_LEDS-1:0] BIT_HI   = BIT_LO << (NUM_LEDS - 1);
   localparam logic [HALF_LO_W-1:0] LO_TOP  = HALF_LO_W'(1) << (HALF_LO_W - 1);
   localparam logic [HALF_UP_W-1:0] UP_TOP  = HALF_UP_W'(1) << (HALF_UP_W - 1);

   logic                 fill_line;
   logic                 fill_half;
   logic [HALF_LO_W-1:0] lo_half;
   logic [HALF_UP_W-1:0] up_half;
   logic [HALF_LO_W-1:0] lo_next;
   logic [HALF_UP_W-1:0] up_next;
   logic [STEP_W-1:0]    dot_wide;
   logic [STEP_W-1:0]    room;
   logic [NUM_LEDS-1:0]  stack;
   logic [NUM_LEDS-1:0]  dot_bit;

   always_comb begin
      fill_line = (cur.step < STEP_LEDS);
      fill_half = (cur.step < STEP_HALF);
      lo_half   = cur.word[HALF_LO_W-1:0];
      up_half   = cur.word[NUM_LEDS-1:HALF_LO_W];
      if (cur.mode == MODE_OUTSIDE_IN) begin
         up_next = (up_half >> 1) | (fill_half ? UP_TOP : '0);
         lo_next = (lo_half << 1) | HALF_LO_W'(fill_half);
      end else begin
         up_next = (up_half << 1) | HALF_UP_W'(fill_half);
         lo_next = (lo_half >> 1) | (fill_half ? LO_TOP : '0);
      end
      dot_wide = STEP_W'(cur.dot);
      room     = STEP_LEDS - cur.step;
      if (cur.mode == MODE_STACK_LOW) begin
         stack   = ALL_ONES << room;
         dot_bit = BIT_LO << cur.dot;
      end else begin
         stack   = ~(ALL_ONES << cur.step);
         dot_bit = BIT_HI >> cur.dot;
      end
   end

   always_comb begin
      nxt       = cur;
      refreshed = 1'b0;
      if (kind == KIND_KEY) begin
         nxt.mode  = (key == MODE_NONE) ? MODE_BLINK : key;
         nxt.word  = '0;
         nxt.step  = '0;
         nxt.dot   = '0;
         refreshed = 1'b1;
      end else begin
         case (cur.mode)
            MODE_BLINK: begin
               nxt.word  = ~cur.word;
               refreshed = 1'b1;
            end
            MODE_FILL_LEFT, MODE_FILL_RIGHT: begin
               if (cur.step <= STEP_FULL) begin
                  if (cur.mode == MODE_FILL_LEFT) begin
                     nxt.word = (cur.word << 1) | NUM_LEDS'(fill_line);
                  end else begin
                     nxt.word = (cur.word >> 1) | (fill_line ? BIT_HI : '0);
                  end
                  nxt.step  = cur.step + 1'b1;
                  refreshed = 1'b1;
               end else begin
                  nxt.step = '0;
               end
            end
            MODE_OUTSIDE_IN, MODE_INSIDE_OUT: begin
               if (cur.step <= STEP_LEDS) begin
                  nxt.word  = {up_next, lo_next};
                  nxt.step  = cur.step + 1'b1;
                  refreshed = 1'b1;
               end else begin
                  nxt.step = '0;
               end
            end
            MODE_STACK_LOW, MODE_STACK_HIGH: begin
               if (cur.step <= STEP_LEDS) begin
                  if (dot_wide < room) begin
                     nxt.word  = stack | dot_bit;
                     nxt.dot   = cur.dot + 1'b1;
                     refreshed = 1'b1;
                  end else begin
                     nxt.dot  = '0;
                     nxt.step = cur.step + 1'b1;
                  end
               end else begin
                  nxt.step = '0;
               end
            end
            default: begin
               // frozen codes: hold everything
               nxt = cur;
            end
         endcase
      end
   end

endmodule

// ----- rtl/led_chaser_pattern_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_chaser_pattern_sequencer_top
// Steps a word of LEDs through seven animations picked by keypad codes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall, req_kind, req_key): kind 0 is an
//   animation tick, kind 1 a key press carrying the code in req_key. A
//   request is taken at a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall, rsp_leds, rsp_refreshed): one
//   response per request, in order, with the LED word after the step and a
//   flag that tells whether the display changed or was redrawn.
//   Path: a taken request lands in the input register, is stepped from there
//   into the response register, and is taken by the receiver from it.
//   Throughput: one request per cycle while rsp_stall is low; the step is a
//   single pass of shift and mask logic between the input register and the
//   response register.
//   Stall: while rsp_stall holds a response, the next request waits unstepped
//   in the input register and req_stall rises only once that register is
//   also full; nothing is dropped.
//   Reset (synchronous, active high): blink mode, LEDs dark, counters zero,
//   both registers empty.
// ----------------------------------------------------------------------------
module led_chaser_pattern_sequencer_top
   import lcps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [3:0]            req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEDS_OUT_W-1:0] rsp_leds,
   output logic                  rsp_refreshed
);

   item_type  item;
   state_type state_ff;
   state_type state_in;
   logic      refreshed;
   logic      out_ready;
   logic      advance;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [LEDS_OUT_W-1:0] rsp_leds_ff;
   logic                  rsp_refreshed_ff;
   logic [WORD_EXT_W-1:0] word_ext;

   // The response register frees up when empty or being taken this edge.
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = item.valid & out_ready;

   lcps_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_key   (req_key),
      .req_stall (req_stall),
      .out_ready (out_ready),
      .item      (item)
   );

   lcps_step u_step (
      .kind      (item.kind),
      .key       (item.key),
      .cur       (state_ff),
      .nxt       (state_in),
      .refreshed (refreshed)
   );

   // Report only the low LED bits; widen first if the word is short.
   assign word_ext = WORD_EXT_W'(state_in.word);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= MODE_BLINK;
         state_ff.word <= '0;
         state_ff.step <= '0;
         state_ff.dot  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Commit the animation state only when the step moves out.
         if (advance) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_leds_ff      <= word_ext[LEDS_OUT_W-1:0];
         rsp_refreshed_ff <= refreshed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_leds      = rsp_leds_ff;
   assign rsp_refreshed = rsp_refreshed_ff;

endmodule
